/* rtl/core/smmu_cq_pkg.sv */
// Package for the command-queue register stub: field widths, request and
// result codes, register offsets and the result record type.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package smmu_cq_pkg;

  localparam int TYPE_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 64;
  localparam int KIND_W  = 3;
  localparam int MADDR_W = 53;

  localparam int REG_WORDS_DEF = 16384;
  localparam int MAX_LOG2_DEF  = 19;

  // Request types.
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RESP  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RDATA    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WDONE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MSI_ZERO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WALKDONE = 3'd4;

  // Register byte offsets.
  localparam logic [ADDR_W-1:0] OFF_CR0      = 16'h0020;
  localparam logic [ADDR_W-1:0] OFF_CR0ACK   = 16'h0024;
  localparam logic [ADDR_W-1:0] OFF_GBPA     = 16'h0044;
  localparam logic [ADDR_W-1:0] OFF_IRQC     = 16'h0050;
  localparam logic [ADDR_W-1:0] OFF_IRQCACK  = 16'h0054;
  localparam logic [ADDR_W-1:0] OFF_QBASE    = 16'h0090;
  localparam logic [ADDR_W-1:0] OFF_QBASE_HI = 16'h0094;
  localparam logic [ADDR_W-1:0] OFF_PROD     = 16'h0098;
  localparam logic [ADDR_W-1:0] OFF_CONS     = 16'h009C;

  localparam logic [3:0] CR0ACK_MASK = 4'hD;

  // Command decode.
  localparam logic [7:0] OPC_SYNC   = 8'h46;
  localparam logic [1:0] CS_SIG_IRQ = 2'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  rdata;
    logic [MADDR_W-1:0] mem_addr;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/smmu_cq_req_if.sv */
// Input channel of the command-queue stub: valid/ready with the request payload.
// Depends on smmu_cq_pkg for the field widths.
`default_nettype none

interface smmu_cq_req_if;
  logic                              valid;
  logic                              ready;
  logic [smmu_cq_pkg::TYPE_W-1:0]    req_type;
  logic [smmu_cq_pkg::ADDR_W-1:0]    addr;
  logic                              wide;
  logic [smmu_cq_pkg::DATA_W-1:0]    wdata;
  logic [smmu_cq_pkg::DATA_W-1:0]    entry_word0;
  logic [smmu_cq_pkg::DATA_W-1:0]    entry_word1;

  modport source (
    output valid, req_type, addr, wide, wdata, entry_word0, entry_word1,
    input  ready
  );
  modport sink (
    input  valid, req_type, addr, wide, wdata, entry_word0, entry_word1,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/smmu_cq_rsp_if.sv */
// Result channel of the command-queue stub: valid/ready with the result payload.
// Depends on smmu_cq_pkg for the field widths.
`default_nettype none

interface smmu_cq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [smmu_cq_pkg::KIND_W-1:0]    kind;
  logic [smmu_cq_pkg::DATA_W-1:0]    rdata;
  logic [smmu_cq_pkg::MADDR_W-1:0]   mem_addr;
  logic                              last;

  modport source (
    output valid, kind, rdata, mem_addr, last,
    input  ready
  );
  modport sink (
    input  valid, kind, rdata, mem_addr, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/smmu_command_queue_stub.sv */
// Top level of the command-queue register stub: register window in a memory,
// shadow flops for the special registers, queue walk logic and a result queue.
// Depends on smmu_cq_pkg, smmu_cq_req_if and smmu_cq_rsp_if.
//
//   channel | dir | payload                                             | role
//   req     | in  | req_type, addr, wide, wdata, entry_word0, entry_word1 | bus access or entry
//   rsp     | out | kind, rdata, mem_addr, last                         | up to two per transaction
//
// The register memory read is registered in the accept cycle, and the next
// cycle computes the results and does the write.
// After reset the register memory is cleared, one word a cycle; req.ready
// stays low until the pass is done.
// A four-entry result queue lets a new transaction in while up to two results wait.
// req.ready also drops when the result queue has fewer than two free entries.
`default_nettype none

module smmu_command_queue_stub #(
  parameter int REG_WORDS     = smmu_cq_pkg::REG_WORDS_DEF,
  parameter int MAX_LOG2_SIZE = smmu_cq_pkg::MAX_LOG2_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  smmu_cq_req_if.sink    req,
  smmu_cq_rsp_if.source  rsp
);

  localparam int IW = $clog2(REG_WORDS);
  localparam logic [14:0] WORDS_L   = 15'(REG_WORDS);
  localparam logic [IW-1:0] LAST_IDX = IW'(REG_WORDS - 1);
  localparam logic [4:0] MAX_LS     = 5'(MAX_LOG2_SIZE);

  localparam logic [13:0] IDX_CR0  = smmu_cq_pkg::OFF_CR0[15:2];
  localparam logic [13:0] IDX_IRQC = smmu_cq_pkg::OFF_IRQC[15:2];
  localparam logic [13:0] IDX_QLO  = smmu_cq_pkg::OFF_QBASE[15:2];
  localparam logic [13:0] IDX_QHI  = smmu_cq_pkg::OFF_QBASE_HI[15:2];
  localparam logic [13:0] IDX_CONS = smmu_cq_pkg::OFF_CONS[15:2];

  // Register memory and its clearing pass.
  logic [31:0]   mem [REG_WORDS];
  logic [31:0]   rd_q;
  logic          clearing;
  logic [IW-1:0] clr_idx;

  // Captured transaction.
  logic                           busy;
  logic [smmu_cq_pkg::TYPE_W-1:0] s_type;
  logic [15:0]                    s_addr;
  logic                           s_wide;
  logic [63:0]                    s_wdata;
  logic [63:0]                    s_w0;
  logic [63:0]                    s_w1;

  // Shadow copies of the registers that side rules read.
  logic [31:0] cr0, cr0_next;
  logic [31:0] irqc, irqc_next;
  logic [31:0] qlo, qlo_next;
  logic [31:0] qhi, qhi_next;
  logic [31:0] cons, cons_next;
  logic [46:0] qbase, qbase_next;
  logic [4:0]  qlog2, qlog2_next;
  logic        walk_active, walk_active_next;
  logic [31:0] walk_cursor, walk_cursor_next;
  logic [31:0] walk_target, walk_target_next;

  // Result queue.
  smmu_cq_pkg::rsp_t fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] push_n;
  smmu_cq_pkg::rsp_t e0, e1;
  logic       pop;

  logic          mem_we;
  logic [31:0]   mem_wval;
  logic          accept;
  logic [13:0]   widx;
  logic          in_win;
  logic [31:0]   word_rd;
  logic [63:0]   rd_val;
  logic [31:0]   w32;
  logic [31:0]   im;
  logic [31:0]   wb;
  logic [31:0]   nx;
  logic [31:0]   adv;
  logic          is_sync;
  logic          start_ok;

  function automatic logic at_target(input logic [31:0] c, input logic [31:0] t,
                                     input logic [31:0] m, input logic [31:0] w);
    at_target = ((c ^ t) & (m | w)) == 32'd0;
  endfunction

  function automatic logic [52:0] entry_addr(input logic [46:0] base,
                                             input logic [31:0] c,
                                             input logic [31:0] m);
    entry_addr = {1'b0, base, 5'd0} + {17'd0, c & m, 4'd0};
  endfunction

  assign accept     = req.valid && req.ready;
  assign req.ready  = !clearing && !busy && (count <= 3'd2);
  assign pop        = rsp.valid && rsp.ready;
  assign rsp.valid  = count != 3'd0;
  assign rsp.kind     = fifo[rd_ptr].kind;
  assign rsp.rdata    = fifo[rd_ptr].rdata;
  assign rsp.mem_addr = fifo[rd_ptr].mem_addr;
  assign rsp.last     = fifo[rd_ptr].last;

  assign widx   = s_addr[15:2];
  assign in_win = {1'b0, widx} < WORDS_L;
  assign w32    = s_wdata[31:0];

  always_comb begin
    if (widx == IDX_CR0) begin
      word_rd = cr0;
    end else if (widx == IDX_IRQC) begin
      word_rd = irqc;
    end else if (widx == IDX_QLO) begin
      word_rd = qlo;
    end else if (widx == IDX_QHI) begin
      word_rd = qhi;
    end else if (widx == IDX_CONS) begin
      word_rd = cons;
    end else begin
      word_rd = rd_q;
    end
  end

  always_comb begin
    if (!in_win) begin
      rd_val = 64'd0;
    end else if (s_addr == smmu_cq_pkg::OFF_CR0ACK) begin
      rd_val = {60'd0, cr0[3:0] & smmu_cq_pkg::CR0ACK_MASK};
    end else if (s_addr == smmu_cq_pkg::OFF_IRQCACK) begin
      rd_val = {32'd0, irqc};
    end else if (s_addr == smmu_cq_pkg::OFF_QBASE && s_wide) begin
      rd_val = {qhi, qlo};
    end else begin
      rd_val = {32'd0, word_rd};
    end
  end

  // Cursor advance: the index wraps to zero and toggles the wrap bit.
  assign im  = (32'd1 << qlog2) - 32'd1;
  assign wb  = 32'd1 << qlog2;
  assign nx  = (walk_cursor & im) + 32'd1;
  assign adv = ((nx & wb) != 32'd0) ? ((walk_cursor & ~im) ^ wb)
                                    : ((walk_cursor & ~im) | nx);
  assign is_sync  = (s_w0[7:0] == smmu_cq_pkg::OPC_SYNC) &&
                    (s_w0[13:12] == smmu_cq_pkg::CS_SIG_IRQ);
  assign start_ok = (qbase != 47'd0) && (qlog2 != 5'd0) && (qlog2 <= MAX_LS);

  always_comb begin
    cr0_next         = cr0;
    irqc_next        = irqc;
    qlo_next         = qlo;
    qhi_next         = qhi;
    cons_next        = cons;
    qbase_next       = qbase;
    qlog2_next       = qlog2;
    walk_active_next = walk_active;
    walk_cursor_next = walk_cursor;
    walk_target_next = walk_target;
    push_n           = 2'd0;
    e0               = '0;
    e1               = '0;
    mem_we           = 1'b0;
    mem_wval         = w32;
    if (busy) begin
      case (s_type)
        smmu_cq_pkg::REQ_RESP: begin
          if (walk_active) begin
            walk_cursor_next = adv;
            if (at_target(adv, walk_target, im, wb)) begin
              walk_active_next = 1'b0;
              cons_next        = adv;
              e1 = '{smmu_cq_pkg::KIND_WALKDONE, {32'd0, adv}, 53'd0, 1'b1};
            end else begin
              e1 = '{smmu_cq_pkg::KIND_FETCH, 64'd0, entry_addr(qbase, adv, im), 1'b1};
            end
            if (is_sync) begin
              e0 = '{smmu_cq_pkg::KIND_MSI_ZERO, 64'd0, {1'b0, s_w1[51:2], 2'd0}, 1'b0};
              push_n = 2'd2;
            end else begin
              e0 = e1;
              push_n = 2'd1;
            end
          end
        end
        smmu_cq_pkg::REQ_READ: begin
          if (!walk_active) begin
            e0     = '{smmu_cq_pkg::KIND_RDATA, rd_val, 53'd0, 1'b1};
            push_n = 2'd1;
          end
        end
        smmu_cq_pkg::REQ_WRITE: begin
          if (!walk_active) begin
            e0     = '{smmu_cq_pkg::KIND_WDONE, 64'd0, 53'd0, 1'b1};
            push_n = 2'd1;
            if (in_win) begin
              if (s_addr == smmu_cq_pkg::OFF_GBPA) begin
                mem_wval = {1'b0, w32[30:0]};
              end
              mem_we = 1'b1;
              if (widx == IDX_CR0) begin
                cr0_next = mem_wval;
              end
              if (widx == IDX_IRQC) begin
                irqc_next = mem_wval;
              end
              if (widx == IDX_QLO) begin
                qlo_next = mem_wval;
              end
              if (widx == IDX_QHI || (s_addr == smmu_cq_pkg::OFF_QBASE && s_wide)) begin
                qhi_next = (widx == IDX_QHI) ? mem_wval : s_wdata[63:32];
              end
              if (widx == IDX_CONS) begin
                cons_next = mem_wval;
              end
              if (s_addr == smmu_cq_pkg::OFF_QBASE || s_addr == smmu_cq_pkg::OFF_QBASE_HI) begin
                qbase_next = {qhi_next[19:0], qlo_next[31:5]};
                qlog2_next = qlo_next[4:0];
              end
              if (s_addr == smmu_cq_pkg::OFF_PROD && start_ok) begin
                walk_cursor_next = cons;
                walk_target_next = w32;
                e0     = '{smmu_cq_pkg::KIND_WDONE, 64'd0, 53'd0, 1'b0};
                push_n = 2'd2;
                if (at_target(cons, w32, im, wb)) begin
                  e1 = '{smmu_cq_pkg::KIND_WALKDONE, {32'd0, cons}, 53'd0, 1'b1};
                end else begin
                  walk_active_next = 1'b1;
                  e1 = '{smmu_cq_pkg::KIND_FETCH, 64'd0, entry_addr(qbase, cons, im), 1'b1};
                end
              end
            end
          end
        end
        default: begin
          push_n = 2'd0;
        end
      endcase
    end
  end

  // Register memory: clearing pass after reset, one write and one read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 32'd0;
    end else if (mem_we) begin
      mem[widx[IW-1:0]] <= mem_wval;
    end
    if (accept) begin
      rd_q <= mem[req.addr[IW+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + IW'(1);
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_type  <= req.req_type;
      s_addr  <= req.addr;
      s_wide  <= req.wide;
      s_wdata <= req.wdata;
      s_w0    <= req.entry_word0;
      s_w1    <= req.entry_word1;
    end
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= e0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cr0         <= 32'd0;
      irqc        <= 32'd0;
      qlo         <= 32'd0;
      qhi         <= 32'd0;
      cons        <= 32'd0;
      qbase       <= 47'd0;
      qlog2       <= 5'd0;
      walk_active <= 1'b0;
      walk_cursor <= 32'd0;
      walk_target <= 32'd0;
      wr_ptr      <= 2'd0;
      rd_ptr      <= 2'd0;
      count       <= 3'd0;
    end else begin
      busy        <= accept;
      cr0         <= cr0_next;
      irqc        <= irqc_next;
      qlo         <= qlo_next;
      qhi         <= qhi_next;
      cons        <= cons_next;
      qbase       <= qbase_next;
      qlog2       <= qlog2_next;
      walk_active <= walk_active_next;
      walk_cursor <= walk_cursor_next;
      walk_target <= walk_target_next;
      wr_ptr      <= wr_ptr + push_n;
      rd_ptr      <= rd_ptr + {1'b0, pop};
      count       <= count + {1'b0, push_n} - {2'd0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("transaction accepted during the memory clearing pass");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute stage held for more than one cycle");

  a_walk_config_valid: assert property (@(posedge clk) disable iff (rst)
    walk_active |-> (qbase != 47'd0 && qlog2 != 5'd0 && qlog2 <= MAX_LS))
    else $error("walk running with an invalid queue configuration");

  a_walk_started_by_write: assert property (@(posedge clk) disable iff (rst)
    $rose(walk_active) |-> $past(busy) && $past(s_type) == smmu_cq_pkg::REQ_WRITE)
    else $error("walk started by something other than a producer write");
`endif

endmodule

`default_nettype wire
